// ===== rtl/gtg_pkg.sv =====
// Package for the go-to-goal velocity controller.
// Constants, register index codes, the gain struct and the CORDIC arctan table.
// No dependencies.
package gtg_pkg;

    // Default parameter values
    localparam int unsigned POSITION_WIDTH_DEF = 24;
    localparam int unsigned CORDIC_STAGES_DEF  = 16;

    // Fixed field widths
    localparam int unsigned GAIN_W      = 16;
    localparam int unsigned SPEED_W     = 16;
    localparam int unsigned YAW_W       = 19;
    localparam int unsigned ANGLE_W     = 20;   // bearing accumulator, Q.16 rad
    localparam int unsigned CFG_INDEX_W = 3;

    // Q.16 constants
    localparam logic signed [ANGLE_W-1:0] PI_Q16       = ANGLE_W'(205887);
    localparam logic        [GAIN_W-1:0]  INV_GAIN_Q16 = GAIN_W'(39797);

    // Register reset values
    localparam int GOAL_X_RST    = 327680;  // 5.0 m
    localparam int GOAL_Y_RST    = 0;
    localparam int TOL_RST       = 6554;    // 0.1 m
    localparam int LIN_GAIN_RST  = 6554;    // 0.1
    localparam int ANG_GAIN_RST  = 6554;    // 0.1
    localparam int MAX_SPEED_RST = 13107;   // 0.2 m/s

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GOAL_X    = 3'd0,
        REG_GOAL_Y    = 3'd1,
        REG_TOLERANCE = 3'd2,
        REG_LIN_GAIN  = 3'd3,
        REG_ANG_GAIN  = 3'd4,
        REG_MAX_SPEED = 3'd5
    } cfg_reg_e;

    typedef struct packed {
        logic [GAIN_W-1:0]  lin_gain;
        logic [GAIN_W-1:0]  ang_gain;
        logic [SPEED_W-1:0] max_speed;
    } gain_cfg_t;

    // round(atan(2^-i) * 65536)
    function automatic logic [15:0] atan_q16(input int unsigned idx);
        logic [15:0] val;
        case (idx)
            0:       val = 16'd51472;
            1:       val = 16'd30386;
            2:       val = 16'd16055;
            3:       val = 16'd8150;
            4:       val = 16'd4091;
            5:       val = 16'd2047;
            6:       val = 16'd1024;
            7:       val = 16'd512;
            8:       val = 16'd256;
            9:       val = 16'd128;
            10:      val = 16'd64;
            11:      val = 16'd32;
            12:      val = 16'd16;
            13:      val = 16'd8;
            14:      val = 16'd4;
            15:      val = 16'd2;
            16:      val = 16'd1;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/gtg_if.sv =====
// Valid/ready channel interfaces: position samples in, velocity commands out.
// Depends on gtg_pkg.
interface gtg_pos_if #(
    parameter int unsigned POSITION_WIDTH = gtg_pkg::POSITION_WIDTH_DEF
);
    logic                             valid;
    logic                             ready;
    logic signed [POSITION_WIDTH-1:0] pos_x;
    logic signed [POSITION_WIDTH-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface gtg_cmd_if;
    logic                             valid;
    logic                             ready;
    logic        [gtg_pkg::SPEED_W-1:0] linear_velocity;
    logic signed [gtg_pkg::YAW_W-1:0]   yaw_rate;
    logic                             at_goal;

    modport source (output valid, output linear_velocity, output yaw_rate,
                    output at_goal, input ready);
    modport sink   (input valid, input linear_velocity, input yaw_rate,
                    input at_goal, output ready);
endinterface

// ===== rtl/gtg_cfg.sv =====
// Configuration register file: goal, arrival tolerance, gains, speed limit.
// Depends on gtg_pkg.
module gtg_cfg #(
    parameter int unsigned POSITION_WIDTH = gtg_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [gtg_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [POSITION_WIDTH-1:0]            cfg_wdata,
    output logic signed [POSITION_WIDTH-1:0]     goal_x,
    output logic signed [POSITION_WIDTH-1:0]     goal_y,
    output logic [POSITION_WIDTH-2:0]            tolerance,
    output gtg_pkg::gain_cfg_t                   gains
);
    localparam int unsigned TOL_W = POSITION_WIDTH - 1;

    logic [POSITION_WIDTH-1:0] goal_x_reg;
    logic [POSITION_WIDTH-1:0] goal_y_reg;
    logic [TOL_W-1:0]          tol_reg;
    gtg_pkg::gain_cfg_t        gains_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_x_reg          <= POSITION_WIDTH'(gtg_pkg::GOAL_X_RST);
            goal_y_reg          <= POSITION_WIDTH'(gtg_pkg::GOAL_Y_RST);
            tol_reg             <= TOL_W'(gtg_pkg::TOL_RST);
            gains_reg.lin_gain  <= gtg_pkg::GAIN_W'(gtg_pkg::LIN_GAIN_RST);
            gains_reg.ang_gain  <= gtg_pkg::GAIN_W'(gtg_pkg::ANG_GAIN_RST);
            gains_reg.max_speed <= gtg_pkg::SPEED_W'(gtg_pkg::MAX_SPEED_RST);
        end
        else if (cfg_wr_en)
        begin
            case (gtg_pkg::cfg_reg_e'(cfg_index))
                gtg_pkg::REG_GOAL_X:    goal_x_reg          <= cfg_wdata;
                gtg_pkg::REG_GOAL_Y:    goal_y_reg          <= cfg_wdata;
                gtg_pkg::REG_TOLERANCE: tol_reg             <= cfg_wdata[TOL_W-1:0];
                gtg_pkg::REG_LIN_GAIN:  gains_reg.lin_gain  <= cfg_wdata[gtg_pkg::GAIN_W-1:0];
                gtg_pkg::REG_ANG_GAIN:  gains_reg.ang_gain  <= cfg_wdata[gtg_pkg::GAIN_W-1:0];
                gtg_pkg::REG_MAX_SPEED: gains_reg.max_speed <= cfg_wdata[gtg_pkg::SPEED_W-1:0];
                default:                ;   // unknown index: ignored
            endcase
        end
    end

    assign goal_x    = $signed(goal_x_reg);
    assign goal_y    = $signed(goal_y_reg);
    assign tolerance = tol_reg;
    assign gains     = gains_reg;

endmodule

// ===== rtl/gtg_cordic.sv =====
// Offset stage plus unrolled CORDIC vectoring pipeline, one register stage per
// iteration. Produces distance (unscaled by 1/K) and bearing. Depends on gtg_pkg.
module gtg_cordic #(
    parameter int unsigned POSITION_WIDTH = gtg_pkg::POSITION_WIDTH_DEF,
    parameter int unsigned CORDIC_STAGES  = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [POSITION_WIDTH-1:0]        pos_x,
    input  logic signed [POSITION_WIDTH-1:0]        pos_y,
    input  logic signed [POSITION_WIDTH-1:0]        goal_x,
    input  logic signed [POSITION_WIDTH-1:0]        goal_y,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [POSITION_WIDTH+1:0]               magnitude,
    output logic signed [gtg_pkg::ANGLE_W-1:0]      bearing
);
    // offsets need P+1 bits; CORDIC growth (K * sqrt 2 < 4) adds two more
    localparam int unsigned W  = POSITION_WIDTH + 3;
    localparam int unsigned N  = CORDIC_STAGES;
    localparam int unsigned ZW = gtg_pkg::ANGLE_W;

    logic                 vld_reg [0:N];
    logic signed [W-1:0]  x_reg   [0:N];
    logic signed [W-1:0]  y_reg   [0:N];
    logic signed [ZW-1:0] z_reg   [0:N];
    logic signed [W-1:0]  x_next  [0:N];
    logic signed [W-1:0]  y_next  [0:N];
    logic signed [ZW-1:0] z_next  [0:N];
    logic                 vld_in  [0:N];
    logic                 rdy     [0:N+1];

    // offset to goal, rotated by pi when it points backwards
    logic signed [POSITION_WIDTH:0] dx;
    logic signed [POSITION_WIDTH:0] dy;

    always_comb
    begin
        dx = $signed({goal_x[POSITION_WIDTH-1], goal_x})
           - $signed({pos_x[POSITION_WIDTH-1], pos_x});
        dy = $signed({goal_y[POSITION_WIDTH-1], goal_y})
           - $signed({pos_y[POSITION_WIDTH-1], pos_y});
        if (dx[POSITION_WIDTH])
        begin
            x_next[0] = -W'(dx);
            y_next[0] = -W'(dy);
            z_next[0] = dy[POSITION_WIDTH] ? -gtg_pkg::PI_Q16 : gtg_pkg::PI_Q16;
        end
        else
        begin
            x_next[0] = W'(dx);
            y_next[0] = W'(dy);
            z_next[0] = '0;
        end
    end

    assign vld_in[0] = in_valid;
    assign in_ready  = rdy[0];
    assign rdy[N+1]  = out_ready;

    genvar k;
    generate
        for (k = 1; k <= N; k++)
        begin : g_iter
            localparam logic signed [ZW-1:0] ATAN =
                $signed({{(ZW-16){1'b0}}, gtg_pkg::atan_q16(k-1)});
            logic signed [W-1:0] xs;
            logic signed [W-1:0] ys;

            assign xs = x_reg[k-1] >>> (k-1);
            assign ys = y_reg[k-1] >>> (k-1);
            assign vld_in[k] = vld_reg[k-1];

            always_comb
            begin
                if (!y_reg[k-1][W-1])
                begin
                    x_next[k] = x_reg[k-1] + ys;
                    y_next[k] = y_reg[k-1] - xs;
                    z_next[k] = z_reg[k-1] + ATAN;
                end
                else
                begin
                    x_next[k] = x_reg[k-1] - ys;
                    y_next[k] = y_reg[k-1] + xs;
                    z_next[k] = z_reg[k-1] - ATAN;
                end
            end
        end

        for (k = 0; k <= N; k++)
        begin : g_stage
            assign rdy[k] = !vld_reg[k] || rdy[k+1];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[k] <= 1'b0;
                end
                else if (rdy[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (rdy[k] && vld_in[k])
                begin
                    x_reg[k] <= x_next[k];
                    y_reg[k] <= y_next[k];
                    z_reg[k] <= z_next[k];
                end
            end
        end
    endgenerate

    // x never goes negative in vectoring mode
    assign out_valid = vld_reg[N];
    assign magnitude = x_reg[N][POSITION_WIDTH+1:0];
    assign bearing   = z_reg[N];

endmodule

// ===== rtl/gtg_cmd.sv =====
// Command stages: gain correction, arrival test and gain products, saturation
// and output register. Depends on gtg_pkg.
module gtg_cmd #(
    parameter int unsigned POSITION_WIDTH = gtg_pkg::POSITION_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [POSITION_WIDTH+1:0]           magnitude,
    input  logic signed [gtg_pkg::ANGLE_W-1:0]  bearing,
    input  logic [POSITION_WIDTH-2:0]           tolerance,
    input  gtg_pkg::gain_cfg_t                  gains,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [gtg_pkg::SPEED_W-1:0]         linear_velocity,
    output logic signed [gtg_pkg::YAW_W-1:0]    yaw_rate,
    output logic                                at_goal
);
    localparam int unsigned DW = POSITION_WIDTH + 2;        // distance width
    localparam int unsigned ZW = gtg_pkg::ANGLE_W;
    localparam int unsigned GW = gtg_pkg::GAIN_W;
    localparam int unsigned SW = gtg_pkg::SPEED_W;
    localparam int unsigned YW = gtg_pkg::YAW_W;

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    // stage 1: distance = magnitude / K
    logic [DW+GW-1:0]     dist_prod;
    logic [DW-1:0]        dist_reg;
    logic signed [ZW-1:0] z1_reg;

    // stage 2: arrival test, gain products
    logic [DW+GW-1:0]     lin_prod;
    logic signed [ZW+GW:0] yaw_prod;
    logic                 goal2_reg;
    logic [DW-1:0]        lin2_reg;
    logic signed [YW-1:0] yaw2_reg;

    // stage 3: saturation, output register
    logic [SW-1:0]        lin_sat;
    logic [SW-1:0]        lin3_reg;
    logic signed [YW-1:0] yaw3_reg;
    logic                 goal3_reg;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign dist_prod = DW'(magnitude) * gtg_pkg::INV_GAIN_Q16;
    assign lin_prod  = gains.lin_gain * dist_reg;
    assign yaw_prod  = $signed({1'b0, gains.ang_gain}) * z1_reg;

    always_comb
    begin
        if (lin2_reg > DW'(gains.max_speed))
        begin
            lin_sat = gains.max_speed;
        end
        else
        begin
            lin_sat = lin2_reg[SW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            dist_reg <= dist_prod[DW+GW-1:GW];
            z1_reg   <= bearing;
        end
        if (r2 && v1_reg)
        begin
            goal2_reg <= (dist_reg <= DW'(tolerance));
            lin2_reg  <= lin_prod[DW+GW-1:GW];
            yaw2_reg  <= yaw_prod[GW+YW-1:GW];
        end
        if (r3 && v2_reg)
        begin
            goal3_reg <= goal2_reg;
            lin3_reg  <= goal2_reg ? '0 : lin_sat;
            yaw3_reg  <= goal2_reg ? '0 : yaw2_reg;
        end
    end

    assign out_valid       = v3_reg;
    assign linear_velocity = lin3_reg;
    assign yaw_rate        = yaw3_reg;
    assign at_goal         = goal3_reg;

endmodule

// ===== rtl/go_to_goal_velocity_top.sv =====
// Top level of the proportional go-to-goal velocity controller.
// Depends on gtg_pkg, gtg_if, gtg_cfg, gtg_cordic, gtg_cmd.
//
//   channel | dir | handshake         | payload
//   --------+-----+-------------------+-------------------------------------------
//   pos     | in  | pos.valid/ready   | pos_x, pos_y (signed Q8.16 m)
//   cmd     | out | cmd.valid/ready   | linear_velocity, yaw_rate, at_goal
//   cfg     | in  | cfg_wr_en         | cfg_index, cfg_wdata
//
// One request per cycle sustained while cmd.ready is high. A request passes
// through one offset stage, one stage per CORDIC iteration, then gain
// correction, gain products and the saturating output register.
// Reset (rst_n low, async) empties the pipeline and loads register defaults.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up under a cmd stall and pos.ready
// stays high until every stage is full.
module go_to_goal_velocity_top #(
    parameter int unsigned POSITION_WIDTH = gtg_pkg::POSITION_WIDTH_DEF,
    parameter int unsigned CORDIC_STAGES  = gtg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gtg_pos_if.sink                           pos,
    gtg_cmd_if.source                         cmd,
    input  logic                              cfg_wr_en,
    input  logic [gtg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [POSITION_WIDTH-1:0]         cfg_wdata
);
    logic signed [POSITION_WIDTH-1:0]    goal_x;
    logic signed [POSITION_WIDTH-1:0]    goal_y;
    logic [POSITION_WIDTH-2:0]           tolerance;
    gtg_pkg::gain_cfg_t                  gains;

    // CORDIC -> command stages
    logic                                vec_valid;
    logic                                vec_ready;
    logic [POSITION_WIDTH+1:0]           magnitude;
    logic signed [gtg_pkg::ANGLE_W-1:0]  bearing;

    gtg_cfg #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .goal_x    (goal_x),
        .goal_y    (goal_y),
        .tolerance (tolerance),
        .gains     (gains)
    );

    // Offset to goal and vectoring: distance * K and bearing in Q.16 rad
    gtg_cordic #(
        .POSITION_WIDTH (POSITION_WIDTH),
        .CORDIC_STAGES  (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pos.valid),
        .in_ready  (pos.ready),
        .pos_x     (pos.pos_x),
        .pos_y     (pos.pos_y),
        .goal_x    (goal_x),
        .goal_y    (goal_y),
        .out_valid (vec_valid),
        .out_ready (vec_ready),
        .magnitude (magnitude),
        .bearing   (bearing)
    );

    // 1/K correction, arrival test, proportional gains, speed clamp
    gtg_cmd #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_cmd (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (vec_valid),
        .in_ready        (vec_ready),
        .magnitude       (magnitude),
        .bearing         (bearing),
        .tolerance       (tolerance),
        .gains           (gains),
        .out_valid       (cmd.valid),
        .out_ready       (cmd.ready),
        .linear_velocity (cmd.linear_velocity),
        .yaw_rate        (cmd.yaw_rate),
        .at_goal         (cmd.at_goal)
    );

endmodule

// ===== rtl/gtg_checker.sv =====
// Port-level assertions for the go-to-goal controller, bound to the top level.
// Depends on gtg_pkg and go_to_goal_velocity_top.
module gtg_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              pos_ready,
    input logic                              cmd_valid,
    input logic                              cmd_ready,
    input logic [gtg_pkg::SPEED_W-1:0]       linear_velocity,
    input logic signed [gtg_pkg::YAW_W-1:0]  yaw_rate,
    input logic                              at_goal
);
    // a stalled result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("cmd.valid dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=>
            $stable(linear_velocity) && $stable(yaw_rate) && $stable(at_goal))
        else $error("cmd payload changed while stalled");

    // arrival forces both commands to zero
    a_goal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && at_goal |-> linear_velocity == '0 && yaw_rate == '0)
        else $error("nonzero command with at_goal set");

    // the pipeline only backs up from a stalled output
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready || !cmd_valid |-> pos_ready)
        else $error("pos.ready low with output draining");

endmodule

bind go_to_goal_velocity_top gtg_checker u_gtg_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .pos_ready       (pos.ready),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .linear_velocity (cmd.linear_velocity),
    .yaw_rate        (cmd.yaw_rate),
    .at_goal         (cmd.at_goal)
);

// ===== test/tb_top.sv =====
// Self-checking testbench for the go-to-goal velocity controller.
// Uses gtg_pkg, the gtg_pos_if / gtg_cmd_if channels and go_to_goal_velocity_top.
// A small scoreboard predicts each velocity command from the accepted position.

typedef logic signed [gtg_pkg::POSITION_WIDTH_DEF-1:0] pos_t;

typedef struct packed {
    logic [gtg_pkg::SPEED_W-1:0] linear_velocity;
    logic [gtg_pkg::YAW_W-1:0]   yaw_rate;
    logic                        at_goal;
} cmd_t;

// Scoreboard: shadow registers, the steering predictor and the queue of
// commands still owed by the block.
class cmd_tracker;
    pos_t        goal_x;
    pos_t        goal_y;
    logic [22:0] tol;
    logic [15:0] lin_gain;
    logic [15:0] ang_gain;
    logic [15:0] max_speed;
    cmd_t        cmd_due[$];
    int          n_pos;
    int          n_cmd;
    int          n_arrived;
    int          n_capped;
    int          fails;
    int          atan_tab[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                  256, 128, 64, 32, 16, 8, 4, 2,
                                  1, 0, 0, 0, 0, 0, 0, 0};

    function new();
        goal_x    = pos_t'(gtg_pkg::GOAL_X_RST);
        goal_y    = pos_t'(gtg_pkg::GOAL_Y_RST);
        tol       = 23'(gtg_pkg::TOL_RST);
        lin_gain  = 16'(gtg_pkg::LIN_GAIN_RST);
        ang_gain  = 16'(gtg_pkg::ANG_GAIN_RST);
        max_speed = 16'(gtg_pkg::MAX_SPEED_RST);
    endfunction

    function void set_reg(logic [2:0] idx, logic [23:0] data);
        case (idx)
            gtg_pkg::REG_GOAL_X:    goal_x    = data;
            gtg_pkg::REG_GOAL_Y:    goal_y    = data;
            gtg_pkg::REG_TOLERANCE: tol       = data[22:0];
            gtg_pkg::REG_LIN_GAIN:  lin_gain  = data[15:0];
            gtg_pkg::REG_ANG_GAIN:  ang_gain  = data[15:0];
            gtg_pkg::REG_MAX_SPEED: max_speed = data[15:0];
            default: ;  // unmapped index, no effect
        endcase
    endfunction

    function cmd_t steer_from_pos(pos_t px, pos_t py);
        longint dx, dy, x, y, z, xs, ys, dist_q, lin, yaw;
        cmd_t   r;
        dx = longint'(goal_x) - longint'(px);
        dy = longint'(goal_y) - longint'(py);
        x  = dx;
        y  = dy;
        z  = 0;
        // left half plane: pre-rotate by pi
        if (dx < 0)
        begin
            x = -dx;
            y = -dy;
            z = (dy >= 0) ? longint'(205887) : longint'(-205887);
        end
        for (int i = 0; i < gtg_pkg::CORDIC_STAGES_DEF && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_tab[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_tab[i];
            end
        end
        dist_q = (x < 0) ? 0 : ((x * 39797) >>> 16);
        if (dist_q <= longint'(tol))
        begin
            r = '{linear_velocity: '0, yaw_rate: '0, at_goal: 1'b1};
            return r;
        end
        lin = (longint'(lin_gain) * dist_q) >>> 16;
        if (lin > longint'(max_speed))
            lin = longint'(max_speed);
        yaw = (longint'(ang_gain) * z) >>> 16;
        r.linear_velocity = lin[15:0];
        r.yaw_rate        = yaw[18:0];
        r.at_goal         = 1'b0;
        return r;
    endfunction

    function void note_pos(pos_t px, pos_t py);
        cmd_t c;
        c = steer_from_pos(px, py);
        n_pos++;
        if (c.at_goal)
            n_arrived++;
        else if (c.linear_velocity == max_speed)
            n_capped++;
        cmd_due.push_back(c);
    endfunction

    function void check_cmd(cmd_t got);
        cmd_t want;
        n_cmd++;
        if (cmd_due.size() == 0)
        begin
            $display("%0t: unexpected command lin=%h yaw=%h at_goal=%b",
                     $time, got.linear_velocity, got.yaw_rate, got.at_goal);
            fails++;
            return;
        end
        want = cmd_due.pop_front();
        if (got.linear_velocity !== want.linear_velocity)
        begin
            $display("%0t: linear_velocity expected %h actual %h",
                     $time, want.linear_velocity, got.linear_velocity);
            fails++;
        end
        if (got.yaw_rate !== want.yaw_rate)
        begin
            $display("%0t: yaw_rate expected %h actual %h",
                     $time, want.yaw_rate, got.yaw_rate);
            fails++;
        end
        if (got.at_goal !== want.at_goal)
        begin
            $display("%0t: at_goal expected %b actual %b",
                     $time, want.at_goal, got.at_goal);
            fails++;
        end
    endfunction

    function int pending();
        return cmd_due.size();
    endfunction
endclass

module tb_top;

    localparam int POS_W     = gtg_pkg::POSITION_WIDTH_DEF;
    localparam int STAGES    = gtg_pkg::CORDIC_STAGES_DEF;
    // pipeline depth in register stages, plus some margin for SETTLE
    localparam int LATENCY   = STAGES + 4;
    localparam int SETTLE    = LATENCY + 8;
    // no request on either channel for this long means the block is stuck;
    // far above the receiver hold-off and any random gap at 82 percent
    localparam int WATCHDOG  = 5000;
    localparam int HOLD_LEN  = 400;

    // indexes outside the register map, writes there must be dropped
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [2:0]       cfg_index;
    logic [POS_W-1:0] cfg_wdata;

    gtg_pos_if pos_ch ();
    gtg_cmd_if cmd_ch ();

    go_to_goal_velocity_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos       (pos_ch),
        .cmd       (cmd_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    cmd_tracker sb = new();

    // idle controls, percent of cycles; changed by the main sequence per phase
    int   send_idle_pct;
    int   stall_pct;
    logic hold_req;
    int   hold_left;
    int   quiet_cycles;

    always #5 clk = ~clk;

    // Every input known from time zero.
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        pos_ch.valid  = 1'b0;
        pos_ch.pos_x  = '0;
        pos_ch.pos_y  = '0;
        cmd_ch.ready  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b0;
        hold_left     = 0;
        quiet_cycles  = 0;
    end

    // Command receiver: random stalls, plus one long hold-off on request
    // so the pipeline fills and backs up into pos.ready.
    always @(posedge clk)
    begin
        if (hold_req && hold_left == 0)
        begin
            hold_left = HOLD_LEN;
            hold_req <= 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            cmd_ch.ready <= 1'b0;
        end
        else
            cmd_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Monitor: samples both channels at the edge, before the block's
    // registers update, and keeps the watchdog.
    always @(posedge clk)
    begin
        cmd_t got;
        bit   moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (pos_ch.valid && pos_ch.ready)
            begin
                sb.note_pos(pos_ch.pos_x, pos_ch.pos_y);
                moved = 1'b1;
            end
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                got.linear_velocity = cmd_ch.linear_velocity;
                got.yaw_rate        = cmd_ch.yaw_rate;
                got.at_goal         = cmd_ch.at_goal;
                sb.check_cmd(got);
                moved = 1'b1;
            end
        end
        if (moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("%0t: watchdog, no request moved for %0d cycles", $time, WATCHDOG);
            $display("== FAIL ==");
            $finish;
        end
    end

    // One position request; random idle cycles before it, then hold
    // until accepted. valid stays high into the next request when no gap.
    task automatic send_pos(input pos_t px, input pos_t py);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pos_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pos_ch.valid <= 1'b1;
        pos_ch.pos_x <= px;
        pos_ch.pos_y <= py;
        do
            @(posedge clk);
        while (!pos_ch.ready);
    endtask

    // Wait until every predicted command has come back, then let the
    // pipeline run empty. First edge lets the monitor log the last request.
    task automatic drain;
        pos_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Back-to-back register writes; call drain first, cfg_done after.
    task automatic write_reg(input logic [2:0] idx, input logic [POS_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic cfg_done;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [POS_W-1:0] gx, input logic [POS_W-1:0] gy,
                             input logic [POS_W-1:0] tl, input logic [15:0] lg,
                             input logic [15:0] ag, input logic [15:0] ms);
        write_reg(gtg_pkg::REG_GOAL_X, gx);
        write_reg(gtg_pkg::REG_GOAL_Y, gy);
        write_reg(gtg_pkg::REG_TOLERANCE, tl);
        write_reg(gtg_pkg::REG_LIN_GAIN, {8'($urandom), lg});  // upper bits dropped
        write_reg(gtg_pkg::REG_ANG_GAIN, {8'($urandom), ag});
        write_reg(gtg_pkg::REG_MAX_SPEED, {8'($urandom), ms});
    endtask

    // Mostly small tolerances so both branches show up, now and then wide.
    task automatic write_random_config;
        logic [POS_W-1:0] tl;
        tl = ($urandom_range(9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(1 << 18));
        write_all(POS_W'($urandom), POS_W'($urandom), tl,
                  16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    function automatic pos_t around(pos_t centre, int span);
        return pos_t'(int'(centre) + int'($urandom_range(2 * span)) - span);
    endfunction

    // Random position: anywhere, close to the goal (straddling the
    // arrival radius), or within a couple of metres of it.
    task automatic send_random(input int count);
        int   k;
        int   span;
        pos_t px;
        pos_t py;
        for (int n = 0; n < count; n++)
        begin
            k = $urandom_range(99);
            if (k < 40)
            begin
                px = pos_t'($urandom);
                py = pos_t'($urandom);
            end
            else
            begin
                span = (k < 75) ? int'(sb.tol) * 2 + 8 : (1 << 17);
                px = around(sb.goal_x, span);
                py = around(sb.goal_y, span);
            end
            send_pos(px, py);
        end
    endtask

    // Directed set, run with the reset register values (goal 5 m, 0 m).
    task automatic send_directed;
        pos_t gx;
        pos_t gy;
        gx = sb.goal_x;
        gy = sb.goal_y;
        send_pos(gx, gy);                                   // zero offset, arrived
        send_pos(pos_t'(gx - 6554), gy);                    // right at the tolerance
        send_pos(pos_t'(gx - 6553), gy);
        send_pos(pos_t'(gx - 6560), gy);                    // just outside
        send_pos(pos_t'(gx - 65536), gy);                   // 1 m, below the speed cap
        send_pos(pos_t'(0), pos_t'(0));                     // 5 m, speed saturated
        send_pos(pos_t'(gx + 65536), gy);                   // goal behind, bearing pi
        send_pos(pos_t'(gx + 65536), pos_t'(gy + 1));       // behind, y offset negative
        send_pos(pos_t'(gx + 65536), pos_t'(gy - 1));       // behind, y offset positive
        send_pos(gx, pos_t'(gy + 65536));                   // straight to the side
        send_pos(gx, pos_t'(gy - 65536));
        send_pos(pos_t'(24'h7FFFFF), pos_t'(24'h7FFFFF));
        send_pos(pos_t'(24'h800000), pos_t'(24'h800000));
        send_pos(pos_t'(24'h7FFFFF), pos_t'(24'h800000));
        send_pos(pos_t'(24'h800000), pos_t'(24'h7FFFFF));
        send_pos(pos_t'(24'h800000), pos_t'(0));
        send_pos(pos_t'(0), pos_t'(24'h7FFFFF));
        send_pos(pos_t'(24'h555555), pos_t'(24'hAAAAAA));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults, full rate on both sides.
        send_directed();
        drain();
        send_random(160);
        drain();

        // Random registers, unmapped indexes too; sender mostly idle.
        write_reg(REG_SPARE_6, POS_W'($urandom));
        write_reg(REG_SPARE_7, POS_W'($urandom));
        write_random_config();
        cfg_done();
        send_idle_pct = 82;
        send_random(180);
        drain();

        // Top corner: largest goal and gains, zero tolerance; receiver stalls.
        write_all(24'h7FFFFF, 24'h800000, 24'h000000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        cfg_done();
        send_idle_pct = 0;
        stall_pct     = 82;
        send_pos(pos_t'(24'h800000), pos_t'(24'h7FFFFF));   // widest offset
        send_pos(sb.goal_x, sb.goal_y);                     // zero offset, tol 0
        send_random(180);
        drain();

        // Bottom corner: zero gains and cap, tolerance all ones (bit 23 dropped).
        write_all(24'h800000, 24'h7FFFFF, 24'hFFFFFF, 16'h0000, 16'h0000, 16'h0000);
        cfg_done();
        send_idle_pct = 15;
        stall_pct     = 15;
        send_pos(pos_t'(24'h7FFFFF), pos_t'(24'h800000));
        send_random(120);
        drain();

        // Back-pressure: receiver holds off while the sender keeps offering.
        write_random_config();
        cfg_done();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req     <= 1'b1;
        send_random(180);
        drain();

        // One more random setting under light idling on both sides.
        write_random_config();
        cfg_done();
        send_idle_pct = 15;
        stall_pct     = 15;
        send_random(80);
        drain();

        $display("Covered %0d position requests, %0d commands checked, %0d mismatches.",
                 sb.n_pos, sb.n_cmd, sb.fails);
        $display("Arrived %0d times, speed capped %0d times, over six register settings.",
                 sb.n_arrived, sb.n_capped);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
